/* design/nna_pkg.sv */
// ----------------------------------------------------------------------------
// nna_pkg
// Shared types and constants of the nearest neighbor association block.
// ----------------------------------------------------------------------------
package nna_pkg;

  localparam int CMD_BITS   = 2;
  localparam int ID_BITS    = 16;
  localparam int MAXD_BITS  = 23;
  localparam logic [MAXD_BITS-1:0] MAXD_RESET = 23'd25600;  // 100.0 in Q15.8
  localparam int DIFF_BITS  = 24;                 // saturated |difference|
  localparam int SQ_BITS    = 2 * DIFF_BITS + 1;  // dx^2 + dy^2

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;  // latch the accepted beat, seed the search
    logic drop;       // append refused, table full
    logic ram_we;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;       // compare pipeline holds entries
  } dp_stat_t;

endpackage

/* design/nna_if.sv */
// ----------------------------------------------------------------------------
// nna_if
// Valid/ready channel interfaces: request, response and configuration.
// ----------------------------------------------------------------------------
interface nna_req_if
  import nna_pkg::*;
#(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          cmd;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [ID_BITS-1:0]           tag_id;

  modport source (output valid, cmd, pos_x, pos_y, tag_id, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, tag_id, output ready);
endinterface

interface nna_rsp_if
  import nna_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] result_id;
  logic               matched;
  logic               status;

  modport source (output valid, result_id, matched, status, input ready);
  modport sink   (input valid, result_id, matched, status, output ready);
endinterface

interface nna_cfg_if
  import nna_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [MAXD_BITS-1:0] max_distance;

  modport source (output valid, max_distance, input ready);
  modport sink   (input valid, max_distance, output ready);
endinterface

/* design/nna_ram.sv */
// ----------------------------------------------------------------------------
// nna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/nna_ctrl.sv */
// ----------------------------------------------------------------------------
// nna_ctrl
// Sequencer: accepts beats, keeps the table fill count, walks the table on
// a query and hands the result to the output register.
// ----------------------------------------------------------------------------
module nna_ctrl
  import nna_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [CMD_BITS-1:0]  req_cmd,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output ctrl_cmd_t            cmd,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
  input  dp_stat_t             stat
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] pred_count, pred_count_next;
  logic [AW-1:0] scan_idx, scan_idx_next;
  logic          out_valid, out_valid_next;
  logic          accept, full, last;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (pred_count == DEPTH_C);
  assign last      = (CW'(scan_idx) == pred_count - CW'(1));
  assign waddr     = pred_count[AW-1:0];
  assign raddr     = scan_idx;
  assign rsp_valid = out_valid;

  always_comb begin
    state_next      = state;
    pred_count_next = pred_count;
    scan_idx_next   = scan_idx;
    out_valid_next  = out_valid;
    cmd             = '0;

    if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          scan_idx_next = '0;
          state_next    = ST_FINISH;
          if (req_cmd == CMD_CLEAR) begin
            pred_count_next = '0;
          end else if (req_cmd == CMD_APPEND) begin
            if (full) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.ram_we      = 1'b1;
              pred_count_next = pred_count + CW'(1);
            end
          end else if (req_cmd == CMD_QUERY && pred_count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (last) begin
          scan_idx_next = '0;
          state_next    = ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx + AW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last entry to leave the compare pipeline
        if (!stat.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pred_count <= '0;
      scan_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pred_count <= pred_count_next;
      scan_idx   <= scan_idx_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

/* design/nna_dp.sv */
// ----------------------------------------------------------------------------
// nna_dp
// Datapath: prediction RAM, limit register, three-stage distance pipeline
// (difference, square, sum and compare) and the result register.
// ----------------------------------------------------------------------------
module nna_dp
  import nna_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
  input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
  input  logic                  cfg_we,
  input  logic [MAXD_BITS-1:0]  cfg_data,
  input  logic [CMD_BITS-1:0]   in_cmd,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic [ID_BITS-1:0]    in_id,
  output logic [ID_BITS-1:0]    result_id,
  output logic                  matched,
  output logic                  status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = 2 * COORD_BITS + ID_BITS;
  localparam int EW = COORD_BITS + DIFF_BITS;

  logic [MAXD_BITS-1:0]  max_distance;
  logic [2*MAXD_BITS-1:0] limit_sq;
  logic [CMD_BITS-1:0]   item_cmd;
  logic [COORD_BITS-1:0] obs_x, obs_y;
  logic                  item_drop;
  logic [SQ_BITS-1:0]    best;
  logic [ID_BITS-1:0]    best_id;
  logic                  best_hit;

  logic [RW-1:0]         rdata;
  logic                  v1, v2, v3;
  logic [DIFF_BITS-1:0]  dx_s2, dy_s2;
  logic [ID_BITS-1:0]    id_s2, id_s3;
  logic [2*DIFF_BITS-1:0] sqx_s3, sqy_s3;

  logic [COORD_BITS-1:0] ent_x, ent_y, dx_raw, dy_raw;
  logic [EW-1:0]         dx_ext, dy_ext;
  logic [DIFF_BITS-1:0]  dx_sat, dy_sat;
  logic [SQ_BITS-1:0]    d2;
  logic                  closer;

  // flip the sign bit: unsigned order then follows signed order
  function automatic logic [COORD_BITS-1:0] biased(input logic [COORD_BITS-1:0] v);
    biased = {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
  endfunction

  nna_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(waddr),
    .wdata({in_x, in_y, in_id}),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAXD_RESET;
    end else if (cfg_we) begin
      max_distance <= cfg_data;
    end
  end

  assign limit_sq = max_distance * max_distance;

  // stage 1: absolute differences, saturated
  assign ent_x  = biased(rdata[RW-1 -: COORD_BITS]);
  assign ent_y  = biased(rdata[ID_BITS +: COORD_BITS]);
  assign dx_raw = (obs_x >= ent_x) ? obs_x - ent_x : ent_x - obs_x;
  assign dy_raw = (obs_y >= ent_y) ? obs_y - ent_y : ent_y - obs_y;
  assign dx_ext = {{DIFF_BITS{1'b0}}, dx_raw};
  assign dy_ext = {{DIFF_BITS{1'b0}}, dy_raw};
  assign dx_sat = (|dx_ext[EW-1:DIFF_BITS]) ? '1 : dx_ext[DIFF_BITS-1:0];
  assign dy_sat = (|dy_ext[EW-1:DIFF_BITS]) ? '1 : dy_ext[DIFF_BITS-1:0];

  // stage 3: sum and strict compare against best so far
  assign d2     = {1'b0, sqx_s3} + {1'b0, sqy_s3};
  assign closer = v3 && (d2 < best);

  assign stat.busy = v1 || v2 || v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      dx_s2 <= dx_sat;
      dy_s2 <= dy_sat;
      id_s2 <= rdata[ID_BITS-1:0];
    end
    if (v2) begin
      sqx_s3 <= dx_s2 * dx_s2;
      sqy_s3 <= dy_s2 * dy_s2;
      id_s3  <= id_s2;
    end

    if (cmd.load_item) begin
      item_cmd  <= in_cmd;
      item_drop <= cmd.drop;
      obs_x     <= biased(in_x);
      obs_y     <= biased(in_y);
      best      <= SQ_BITS'(limit_sq);
      best_id   <= in_id;
      best_hit  <= 1'b0;
    end else if (closer) begin
      best     <= d2;
      best_id  <= id_s3;
      best_hit <= 1'b1;
    end

    if (cmd.out_load) begin
      result_id <= (item_cmd == CMD_QUERY) ? best_id : '0;
      matched   <= (item_cmd == CMD_QUERY) && best_hit;
      status    <= item_drop;
    end
  end

endmodule

/* design/nearest_neighbor_association.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_association
// Nearest neighbor data association over a table of predicted landmarks.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command beat: clear the table, append a prediction
//   (pos_x, pos_y, tag_id) or query with an observation. rsp returns exactly
//   one beat per request: the matched id (or the observation's own id; zero
//   for clear and append), a matched flag and a status flag that marks an
//   append dropped on a full table. cfg writes the match limit max_distance
//   (Q15.8); the user must keep cfg writes to idle, as the block itself does
//   nothing to enforce this. A query on a non-empty table scans it, one entry
//   per cycle through the RAM read port, then waits in the drain state for
//   the compare pipeline to empty. One request is in work at a time;
//   req_ready returns the cycle after the response is loaded. Reset empties
//   the table, restores max_distance to 100.0 and drops any pending response.
//   A stalled response holds in the output register; the next request is
//   still accepted and waits for the register to free up.
// ----------------------------------------------------------------------------
module nearest_neighbor_association
  import nna_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic      clk,
  input  logic      rst,
  nna_req_if.sink   req,
  nna_rsp_if.source rsp,
  nna_cfg_if.sink   cfg
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ctrl_cmd_t     cmd;
  dp_stat_t      stat;
  logic [AW-1:0] waddr, raddr;

  assign cfg.ready = 1'b1;

  nna_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_cmd  (req.cmd),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .cmd      (cmd),
    .waddr    (waddr),
    .raddr    (raddr),
    .stat     (stat)
  );

  nna_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .waddr    (waddr),
    .raddr    (raddr),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.max_distance),
    .in_cmd   (req.cmd),
    .in_x     (COORD_BITS'(req.pos_x)),
    .in_y     (COORD_BITS'(req.pos_y)),
    .in_id    (req.tag_id),
    .result_id(rsp.result_id),
    .matched  (rsp.matched),
    .status   (rsp.status)
  );

endmodule

/* design/nna_checker.sv */
// ----------------------------------------------------------------------------
// nna_checker
// Port-level assertions for the association block, bound to the top level.
// ----------------------------------------------------------------------------
module nna_checker
  import nna_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [ID_BITS-1:0] result_id,
  input logic               matched,
  input logic               status
);

  // one request in work at a time: accept closes the request side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready stayed high after an accepted beat");

  // stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_id) &&
                                $stable(matched) && $stable(status))
    else $error("response beat changed while stalled");

  // a match only comes from a query, never with a dropped append
  a_match_no_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && matched |-> !status)
    else $error("matched and status both set");

  // dropped append returns a zero id
  a_drop_zero_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> result_id == '0)
    else $error("dropped append returned a nonzero id");

  // nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind nearest_neighbor_association nna_checker u_nna_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .result_id(rsp.result_id),
  .matched  (rsp.matched),
  .status   (rsp.status)
);
